// ===== src/skts_pkg.sv =====
// Shared constants and types for the sorted key table search block.
package skts_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int KEY_W = 32;
    localparam int PAY_W = 16;
    localparam int ENT_W = KEY_W + PAY_W;
    localparam int POS_W = 10;
    localparam int CNT_W = 11;
    localparam int OP_W = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
    localparam logic [OP_W-1:0] OP_RSVD   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SORT_RD,
        ST_SORT_LD,
        ST_SORT_CMP,
        ST_SORT_PUT,
        ST_BS_RD,
        ST_BS_CMP
    } state_t;

    typedef struct packed {
        logic we;
        logic rd;
    } mem_ctl_t;

endpackage

// ===== src/skts_ram.sv =====
// Single-clock table memory: one write port, one registered read port.
module skts_ram #(
    parameter int DEPTH = skts_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int W     = skts_pkg::ENT_W
) (
    input  logic                 clk,
    input  skts_pkg::mem_ctl_t   ctl,
    input  logic [AW-1:0]        waddr,
    input  logic [W-1:0]         wdata,
    input  logic [AW-1:0]        raddr,
    output logic [W-1:0]         rdata
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/sorted_key_table_search_top.sv =====
// Sorted key table: append, clear, and sort-on-demand binary search.
// Insert, clear and unused op register their result word in the cycle after accept.
// A search on an unsorted table with more than one entry first insertion sorts the
// table in place, then runs the binary search.
// Reset (async, active low) empties the table; no clearing pass is needed.
module sorted_key_table_search_top #(
    parameter int TABLE_DEPTH = skts_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [skts_pkg::OP_W-1:0]     op,
    input  logic signed [skts_pkg::KEY_W-1:0] key,
    input  logic [skts_pkg::PAY_W-1:0]    payload,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          found,
    output logic [skts_pkg::POS_W-1:0]    position,
    output logic [skts_pkg::PAY_W-1:0]    found_payload,
    output logic                          overflow,
    output logic [skts_pkg::CNT_W-1:0]    entry_count
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int KW = skts_pkg::KEY_W;
    localparam int PW = skts_pkg::PAY_W;
    localparam int EW = skts_pkg::ENT_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    skts_pkg::state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          sorted_reg, sorted_next;
    logic [CW-1:0] i_reg, i_next;      // element being inserted
    logic [CW-1:0] j_reg, j_next;      // hole position during the shift
    logic signed [KW-1:0] k_reg, k_next;
    logic [PW-1:0] p_reg, p_next;
    logic [CW-1:0] lo_reg, lo_next;    // search window [lo, hi)
    logic [CW-1:0] hi_reg, hi_next;
    logic [AW-1:0] mid_reg, mid_next;
    logic signed [KW-1:0] tkey_reg, tkey_next;

    logic          out_valid_reg, out_valid_next;
    logic          found_reg, found_next;
    logic [skts_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [PW-1:0] fpay_reg, fpay_next;
    logic          ovf_reg, ovf_next;
    logic [skts_pkg::CNT_W-1:0] ecnt_reg, ecnt_next;

    skts_pkg::mem_ctl_t mem_ctl;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;
    logic signed [KW-1:0] rkey;
    logic [PW-1:0] rpay;
    logic [CW:0]   mid_sum;
    logic [AW-1:0] mid_calc;
    logic          in_fire, out_fire, load_out;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;
    assign in_ready = (state_reg == skts_pkg::ST_IDLE) && (!out_valid_reg || out_ready);
    assign rkey     = rdata[EW-1:PW];
    assign rpay     = rdata[PW-1:0];
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg} - (CW+1)'(1);
    assign mid_calc = mid_sum[AW:1];

    skts_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .W     (EW)
    ) u_ram (
        .clk   (clk),
        .ctl   (mem_ctl),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            skts_pkg::ST_IDLE:
            begin
                if (in_fire && op == skts_pkg::OP_SEARCH)
                begin
                    if (!sorted_reg && cnt_reg > ONE_C)
                        state_next = skts_pkg::ST_SORT_RD;
                    else
                        state_next = skts_pkg::ST_BS_RD;
                end
            end
            skts_pkg::ST_SORT_RD:  state_next = skts_pkg::ST_SORT_LD;
            skts_pkg::ST_SORT_LD:  state_next = skts_pkg::ST_SORT_CMP;
            skts_pkg::ST_SORT_CMP:
            begin
                if (!(rkey > k_reg) || j_reg == ONE_C)
                    state_next = skts_pkg::ST_SORT_PUT;
            end
            skts_pkg::ST_SORT_PUT:
            begin
                if (i_reg + ONE_C == cnt_reg)
                    state_next = skts_pkg::ST_BS_RD;
                else
                    state_next = skts_pkg::ST_SORT_RD;
            end
            skts_pkg::ST_BS_RD:
            begin
                if (lo_reg < hi_reg)
                    state_next = skts_pkg::ST_BS_CMP;
                else
                    state_next = skts_pkg::ST_IDLE;
            end
            skts_pkg::ST_BS_CMP:
            begin
                if (rkey == tkey_reg)
                    state_next = skts_pkg::ST_IDLE;
                else
                    state_next = skts_pkg::ST_BS_RD;
            end
            default: state_next = skts_pkg::ST_IDLE;
        endcase
    end

    // memory control and datapath
    always_comb
    begin
        mem_ctl     = '0;
        waddr       = '0;
        wdata       = '0;
        raddr       = '0;
        cnt_next    = cnt_reg;
        sorted_next = sorted_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        p_next      = p_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        tkey_next   = tkey_reg;
        load_out    = 1'b0;
        found_next  = 1'b0;
        pos_next    = '0;
        fpay_next   = '0;
        ovf_next    = 1'b0;
        case (state_reg)
            skts_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (op)
                        skts_pkg::OP_INSERT:
                        begin
                            load_out = 1'b1;
                            if (cnt_reg < DEPTH_C)
                            begin
                                mem_ctl.we  = 1'b1;
                                waddr       = cnt_reg[AW-1:0];
                                wdata       = {key, payload};
                                cnt_next    = cnt_reg + ONE_C;
                                sorted_next = 1'b0;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        skts_pkg::OP_SEARCH:
                        begin
                            tkey_next = key;
                            i_next    = ONE_C;
                            lo_next   = '0;
                            hi_next   = cnt_reg;
                            if (sorted_reg || cnt_reg <= ONE_C)
                                sorted_next = 1'b1;
                        end
                        skts_pkg::OP_CLEAR:
                        begin
                            load_out    = 1'b1;
                            cnt_next    = '0;
                            sorted_next = 1'b0;
                        end
                        default: load_out = 1'b1;
                    endcase
                end
            end
            skts_pkg::ST_SORT_RD:
            begin
                mem_ctl.rd = 1'b1;
                raddr      = i_reg[AW-1:0];
            end
            skts_pkg::ST_SORT_LD:
            begin
                k_next     = rkey;
                p_next     = rpay;
                j_next     = i_reg;
                mem_ctl.rd = 1'b1;
                raddr      = AW'(i_reg - ONE_C);
            end
            skts_pkg::ST_SORT_CMP:
            begin
                if (rkey > k_reg)
                begin
                    // shift the larger entry up one slot, read the next one down
                    mem_ctl.we = 1'b1;
                    waddr      = j_reg[AW-1:0];
                    wdata      = rdata;
                    j_next     = j_reg - ONE_C;
                    mem_ctl.rd = (j_reg != ONE_C);
                    raddr      = AW'(j_reg - CW'(2));
                end
            end
            skts_pkg::ST_SORT_PUT:
            begin
                mem_ctl.we = 1'b1;
                waddr      = j_reg[AW-1:0];
                wdata      = {k_reg, p_reg};
                i_next     = i_reg + ONE_C;
                if (i_reg + ONE_C == cnt_reg)
                    sorted_next = 1'b1;
            end
            skts_pkg::ST_BS_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    mem_ctl.rd = 1'b1;
                    raddr      = mid_calc;
                    mid_next   = mid_calc;
                end
                else
                begin
                    load_out = 1'b1;
                end
            end
            skts_pkg::ST_BS_CMP:
            begin
                if (rkey == tkey_reg)
                begin
                    load_out   = 1'b1;
                    found_next = 1'b1;
                    pos_next   = skts_pkg::POS_W'(mid_reg);
                    fpay_next  = rpay;
                end
                else if (rkey > tkey_reg)
                begin
                    hi_next = CW'(mid_reg);
                end
                else
                begin
                    lo_next = CW'(mid_reg) + ONE_C;
                end
            end
            default: ;
        endcase
        ecnt_next = skts_pkg::CNT_W'(cnt_next);
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_fire)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= skts_pkg::ST_IDLE;
            cnt_reg       <= '0;
            sorted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sorted_reg    <= sorted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg    <= i_next;
        j_reg    <= j_next;
        k_reg    <= k_next;
        p_reg    <= p_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        tkey_reg <= tkey_next;
        if (load_out)
        begin
            found_reg <= found_next;
            pos_reg   <= pos_next;
            fpay_reg  <= fpay_next;
            ovf_reg   <= ovf_next;
            ecnt_reg  <= ecnt_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign position      = pos_reg;
    assign found_payload = fpay_reg;
    assign overflow      = ovf_reg;
    assign entry_count   = ecnt_reg;

    // fill level never passes the table size
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH_C)
        else $error("entry count above table depth");

    // output slot stays free while a search is in progress
    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != skts_pkg::ST_IDLE |-> !out_valid_reg)
        else $error("result word pending during search");

    // writes stay inside the filled part of the table or at the next free slot
    a_wr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctl.we |-> CW'(waddr) <= cnt_reg)
        else $error("table write beyond fill level");

    // a hit and an overflow never come from the same word
    a_hit_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && found_next |-> !ovf_next && state_reg == skts_pkg::ST_BS_CMP)
        else $error("inconsistent result word");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the sorted key table search block.
module tb_top;

    localparam int DEPTH       = 1024;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int KEY_W       = skts_pkg::KEY_W;
    localparam int PAY_W       = skts_pkg::PAY_W;
    localparam int POS_W       = skts_pkg::POS_W;
    localparam int CNT_W       = skts_pkg::CNT_W;
    localparam int OP_W        = skts_pkg::OP_W;

    // One expected output word
    typedef struct {
        logic                found;
        logic [POS_W-1:0]    position;
        logic [PAY_W-1:0]    found_payload;
        logic                overflow;
        logic [CNT_W-1:0]    entry_count;
    } table_word_t;

    // Scoreboard: keeps a shadow copy of the table and the queue of pending words.
    class table_scoreboard;
        logic [KEY_W-1:0] keys[DEPTH];
        logic [PAY_W-1:0] pays[DEPTH];
        int               n_entries;
        bit               sorted_mark;
        table_word_t      pending[$];
        int               errors;
        int               n_found;
        int               n_overflow;

        function new();
            n_entries   = 0;
            sorted_mark = 0;
            errors      = 0;
            n_found     = 0;
            n_overflow  = 0;
        endfunction

        // Stable insertion sort on signed key
        function void sort_entries();
            logic signed [KEY_W-1:0] k;
            logic [PAY_W-1:0]        p;
            int                      j;
            for (int i = 1; i < n_entries; i++)
            begin
                k = keys[i];
                p = pays[i];
                j = i;
                while (j > 0 && $signed(keys[j-1]) > k)
                begin
                    keys[j] = keys[j-1];
                    pays[j] = pays[j-1];
                    j--;
                end
                keys[j] = k;
                pays[j] = p;
            end
        endfunction

        function void note_input(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                 logic [PAY_W-1:0] pay);
            table_word_t w;
            int          lo;
            int          hi;
            int          mid;
            w = '{default: '0};
            if (op == skts_pkg::OP_INSERT)
            begin
                if (n_entries < DEPTH)
                begin
                    keys[n_entries] = key;
                    pays[n_entries] = pay;
                    n_entries++;
                    sorted_mark = 0;
                end
                else
                begin
                    w.overflow = 1'b1;
                    n_overflow++;
                end
            end
            else if (op == skts_pkg::OP_SEARCH)
            begin
                if (!sorted_mark)
                begin
                    sort_entries();
                    sorted_mark = 1;
                end
                lo = 0;
                hi = n_entries - 1;
                while (lo <= hi)
                begin
                    mid = (lo + hi) / 2;
                    if (keys[mid] == key)
                    begin
                        w.found         = 1'b1;
                        w.position      = mid[POS_W-1:0];
                        w.found_payload = pays[mid];
                        n_found++;
                        break;
                    end
                    else if ($signed(keys[mid]) > $signed(key))
                        hi = mid - 1;
                    else
                        lo = mid + 1;
                end
            end
            else if (op == skts_pkg::OP_CLEAR)
            begin
                n_entries   = 0;
                sorted_mark = 0;
            end
            w.entry_count = n_entries[CNT_W-1:0];
            pending.push_back(w);
        endfunction

        function void check_word(table_word_t got);
            table_word_t exp;
            if (pending.size() == 0)
            begin
                $error("output word with nothing expected");
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.found !== exp.found)
            begin
                $error("found: expected %0d, actual %0d", exp.found, got.found);
                errors++;
            end
            if (got.position !== exp.position)
            begin
                $error("position: expected %0d, actual %0d", exp.position, got.position);
                errors++;
            end
            if (got.found_payload !== exp.found_payload)
            begin
                $error("found_payload: expected %0h, actual %0h",
                       exp.found_payload, got.found_payload);
                errors++;
            end
            if (got.overflow !== exp.overflow)
            begin
                $error("overflow: expected %0d, actual %0d", exp.overflow, got.overflow);
                errors++;
            end
            if (got.entry_count !== exp.entry_count)
            begin
                $error("entry_count: expected %0d, actual %0d",
                       exp.entry_count, got.entry_count);
                errors++;
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [OP_W-1:0]         op;
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
    logic                    out_valid;
    logic                    out_ready;
    logic                    found;
    logic [POS_W-1:0]        position;
    logic [PAY_W-1:0]        found_payload;
    logic                    overflow;
    logic [CNT_W-1:0]        entry_count;

    table_scoreboard sb;
    int              cycles;
    int              words_in;
    int              words_out;
    bit              hold_rx;        // long receiver hold-off request
    logic [KEY_W-1:0] key_pool[16];  // recent keys, reused to make hits likely

    sorted_key_table_search_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .key           (key),
        .payload       (payload),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found         (found),
        .position      (position),
        .found_payload (found_payload),
        .overflow      (overflow),
        .entry_count   (entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap length: mostly zero or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Offer one word and hold it until accepted. The prediction is noted at accept.
    task automatic send_word(logic [OP_W-1:0] o, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
        in_valid <= 1'b1;
        op       <= o;
        key      <= k;
        payload  <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_input(o, k, p);
        words_in++;
    endtask

    task automatic idle_sender(int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    // Random key: from the pool, a corner value, or fully random
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return key_pool[$urandom_range(0, 15)];
        else if (r == 4)
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        else
            return $urandom();
    endfunction

    task automatic random_word();
        logic [KEY_W-1:0] k;
        int               r;
        logic [OP_W-1:0]  o;
        k = pick_key();
        r = $urandom_range(0, 99);
        // Inserts dominate so searches meet tables of many sizes
        if (r < 55)
            o = skts_pkg::OP_INSERT;
        else if (r < 94)
            o = skts_pkg::OP_SEARCH;
        else if (r < 98)
            o = skts_pkg::OP_CLEAR;
        else
            o = skts_pkg::OP_RSVD;
        if (o == skts_pkg::OP_INSERT && $urandom_range(0, 3) == 0)
            key_pool[$urandom_range(0, 15)] = k;
        send_word(o, k, $urandom());
        idle_sender(gap_len());
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_rx)
            out_ready <= 1'b0;
        else if ($urandom_range(0, 99) < 8)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_word('{found, position, found_payload, overflow, entry_count});
            words_out++;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Long receiver hold-off, counted here while the sender keeps offering words
    initial
    begin
        hold_rx = 1'b0;
        wait (words_in >= 40);
        @(posedge clk);
        hold_rx = 1'b1;
        repeat (300) @(posedge clk);
        hold_rx = 1'b0;
    end

    initial
    begin
        sb        = new();
        cycles    = 0;
        words_in  = 0;
        words_out = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        op        = skts_pkg::OP_INSERT;
        key       = '0;
        payload   = '0;
        for (int i = 0; i < 16; i++)
            key_pool[i] = $urandom_range(0, 20) - 10;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty search, extremes, duplicates, unused op, clear
        send_word(skts_pkg::OP_SEARCH, 32'd5, 16'h0);
        send_word(skts_pkg::OP_RSVD, 32'hFFFF_FFFF, 16'hFFFF);
        send_word(skts_pkg::OP_INSERT, 32'h7FFF_FFFF, 16'hFFFF);
        send_word(skts_pkg::OP_INSERT, 32'h8000_0000, 16'h0001);
        send_word(skts_pkg::OP_INSERT, 32'h0000_0000, 16'h0000);
        send_word(skts_pkg::OP_INSERT, 32'hFFFF_FFFF, 16'h8000);
        send_word(skts_pkg::OP_INSERT, 32'd7, 16'h1111);
        send_word(skts_pkg::OP_INSERT, 32'd7, 16'h2222);
        send_word(skts_pkg::OP_INSERT, 32'd7, 16'h3333);
        send_word(skts_pkg::OP_SEARCH, 32'h8000_0000, 16'hAAAA);
        send_word(skts_pkg::OP_SEARCH, 32'h7FFF_FFFF, 16'h0);
        send_word(skts_pkg::OP_SEARCH, 32'd7, 16'h0);
        send_word(skts_pkg::OP_SEARCH, 32'hFFFF_FFFF, 16'h0);
        send_word(skts_pkg::OP_SEARCH, 32'd6, 16'h0);
        send_word(skts_pkg::OP_INSERT, 32'd6, 16'h5555);
        send_word(skts_pkg::OP_SEARCH, 32'd6, 16'h0);
        send_word(skts_pkg::OP_RSVD, 32'd0, 16'h0);
        send_word(skts_pkg::OP_CLEAR, 32'd0, 16'h0);
        send_word(skts_pkg::OP_SEARCH, 32'd7, 16'h0);

        // Sender pause until all words are back
        wait_drained();

        // Random traffic on small tables
        repeat (280)
            random_word();

        // Build a larger table with periodic searches, then search it hard
        wait_drained();
        send_word(skts_pkg::OP_CLEAR, 32'd0, 16'h0);
        for (int i = 0; i < 64; i++)
        begin
            if (i % 16 == 0)
                send_word(skts_pkg::OP_SEARCH, pick_key(), 16'h0);
            send_word(skts_pkg::OP_INSERT, $urandom_range(0, 127) - 64, $urandom());
        end
        repeat (20)
            send_word(skts_pkg::OP_SEARCH, $urandom_range(0, 127) - 64, 16'h0);
        send_word(skts_pkg::OP_INSERT, 32'd3, 16'h3);
        send_word(skts_pkg::OP_CLEAR, 32'd0, 16'h0);
        repeat (60)
            random_word();

        wait_drained();
        repeat (50) @(posedge clk);

        $display("Run covered %0d input words and %0d output words: %0d searches hit,",
                 words_in, words_out, sb.n_found);
        $display("%0d inserts overflowed a full table, with stalls on both sides.",
                 sb.n_overflow);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
